/* hw/rtl/coalescing_backoff_work_queue_core_assert.svh */
// ============================================================================
// Assertion macros for the coalescing backoff work queue
// Clocked concurrent checks, disabled while reset is held.
// ============================================================================
`ifndef COALESCING_BACKOFF_WORK_QUEUE_CORE_ASSERT_SVH
`define COALESCING_BACKOFF_WORK_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define CBWQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbwq assertion failed");

// next-cycle implication
`define CBWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbwq assertion failed");

`endif

/* hw/rtl/cbwq_pkg.sv */
// ============================================================================
// cbwq_pkg
// Types, codes and helpers shared by the work queue modules.
// ============================================================================
`default_nettype none

package cbwq_pkg;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int CFG_W     = 10;
    localparam int DELAY_W   = 10;
    localparam int TIME_W    = 32;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_PEEK   = 2'd1;
    localparam logic [1:0] OP_RETIRE = 2'd2;

    localparam logic CFG_MIN_BACKOFF = 1'b0;
    localparam logic CFG_MAX_BACKOFF = 1'b1;

    localparam logic [CFG_W-1:0] RESET_MIN_BACKOFF = 10'd10;
    localparam logic [CFG_W-1:0] RESET_MAX_BACKOFF = 10'd1000;

    typedef struct packed {
        logic        from_root;
        logic [3:0]  source_id;
        logic [15:0] generation;
        logic [7:0]  port;
    } t_key;

    typedef struct packed {
        logic               conn;
        logic               obs;
        logic [DELAY_W-1:0] delay;
    } t_backoff;

    typedef struct packed {
        t_key              key;
        t_backoff          backoff;
        logic [TIME_W-1:0] retry_time;
    } t_entry;

    typedef struct packed {
        t_backoff          backoff;
        logic [TIME_W-1:0] retry_time;
        logic [TIME_W-1:0] now;
        logic              obs_valid;
        logic              obs_conn;
        logic [CFG_W-1:0]  min_backoff;
        logic [CFG_W-1:0]  max_backoff;
    } t_retire_req;

    typedef struct packed {
        t_backoff          backoff;
        logic [TIME_W-1:0] retry_time;
    } t_retire_rsp;

    // result fields, lowest bit first from the bottom member up
    typedef struct packed {
        logic [3:0] queue_count;
        t_key       head_key;
        logic       head_ready;
        logic       head_valid;
        logic       merged;
        logic       accepted;
    } t_result;

    // zero retry time means always ready, otherwise wrapping compare
    function automatic logic is_ready(input logic [TIME_W-1:0] t,
                                      input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] diff;
        diff = now - t;
        return (t == '0) || !diff[TIME_W-1];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cbwq_entry_ram.sv */
// ============================================================================
// cbwq_entry_ram
// Entry store: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module cbwq_entry_ram #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire cbwq_pkg::t_entry   i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr,
    output cbwq_pkg::t_entry        o_rdata
);

    cbwq_pkg::t_entry r_mem [DEPTH];
    cbwq_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

/* hw/rtl/cbwq_backoff.sv */
// ============================================================================
// cbwq_backoff
// Retry update of one entry: observed-state check, delay advance, new time.
// ============================================================================
`default_nettype none

module cbwq_backoff (
    input  wire cbwq_pkg::t_retire_req i_req,
    output cbwq_pkg::t_retire_rsp      o_rsp
);

    logic                            was_ready;
    logic [cbwq_pkg::DELAY_W-1:0]    delay;
    logic [cbwq_pkg::DELAY_W:0]      dbl;
    logic                            obs;
    logic                            conn;
    logic [cbwq_pkg::TIME_W-1:0]     t;

    always_comb begin
        // readiness is judged on the stored time, before the observation
        was_ready = cbwq_pkg::is_ready(i_req.retry_time, i_req.now);
        delay     = i_req.backoff.delay;
        obs       = i_req.backoff.obs;
        conn      = i_req.backoff.conn;
        t         = i_req.retry_time;
        dbl       = {i_req.backoff.delay, 1'b0};
        if (i_req.obs_valid) begin
            // a new or changed connection state restarts the backoff
            if (!obs || (conn != i_req.obs_conn)) begin
                delay = '0;
                t     = '0;
            end
            obs  = 1'b1;
            conn = i_req.obs_conn;
        end
        if (was_ready) begin
            dbl = {delay, 1'b0};
            if (delay == '0) begin
                delay = i_req.min_backoff;
            end else if (delay < i_req.max_backoff) begin
                delay = (dbl > {1'b0, i_req.max_backoff}) ? i_req.max_backoff
                                                          : dbl[cbwq_pkg::DELAY_W-1:0];
            end
            t = i_req.now + {{(cbwq_pkg::TIME_W-cbwq_pkg::DELAY_W){1'b0}}, delay};
        end
    end

    assign o_rsp.backoff.conn  = conn;
    assign o_rsp.backoff.obs   = obs;
    assign o_rsp.backoff.delay = delay;
    assign o_rsp.retry_time    = t;

endmodule

`default_nettype wire

/* hw/rtl/coalescing_backoff_work_queue_core.sv */
// ============================================================================
// coalescing_backoff_work_queue_core
// Ring of port-change work entries with key coalescing and retry backoff.
// ============================================================================
// Requests enter on the s_axis channel (tuser = operation, tdata = key, time
// and retire outcome) and each one yields exactly one result on m_axis.
// Config writes (i_cfg_we/i_cfg_index/i_cfg_wdata) go straight into the limit registers and are
// meant to be issued while no request is in flight.
// One request is processed at a time; s_axis_tready is high only when idle.
// Each operation ends by reading the head and building the result (ST_HEAD,
// ST_HWAIT, ST_DONE). Peek, complete retire and retire on an empty ring go
// there directly; a retry retire first reads the head and rotates it to the
// tail (ST_RREAD, ST_RMOD); a push first scans the queued entries, one entry
// compared per cycle (ST_SCAN), and appends on a miss if a slot is free.
// The push scan over the single read port of the entry RAM sets the rate.
// The result sits in an output register; the next request is taken while it
// waits, but a further result is held back until m_axis_tready frees it.
// Reset (synchronous, active low) empties the ring, restores the default
// backoff limits and drops any pending result; entry RAM is not cleared.
// ============================================================================
`default_nettype none

module coalescing_backoff_work_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_index,
    input  wire logic [cbwq_pkg::CFG_W-1:0]        i_cfg_wdata,
    // request channel
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // from_root[0], source_id[4:1], source_generation[20:5], port[28:21],
    // now_ms[60:29], outcome_retry[61], observed_valid[62],
    // observed_connected[63]
    input  wire logic [cbwq_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation[1:0]
    input  wire logic [cbwq_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // result channel
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // accepted[0], merged[1], head_valid[2], head_ready[3], head_from_root[4],
    // head_source_id[8:5], head_generation[24:9], head_port[32:25],
    // queue_count[36:33], zero fill[39:37]
    output logic [cbwq_pkg::M_TDATA_W-1:0]         m_axis_tdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = PW + 1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SCAN   = 8'b0000_0010,
        ST_APPEND = 8'b0000_0100,
        ST_RREAD  = 8'b0000_1000,
        ST_RMOD   = 8'b0001_0000,
        ST_HEAD   = 8'b0010_0000,
        ST_HWAIT  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    t_state                        r_state, n_state;
    logic [PW-1:0]                 r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]                 r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]                 r_scan, n_scan;
    logic                          r_pend, n_pend;
    logic [PW-1:0]                 r_pend_addr, n_pend_addr;
    logic                          r_acc, n_acc;
    logic                          r_mrg, n_mrg;
    cbwq_pkg::t_result             r_res, n_res;
    cbwq_pkg::t_result             r_out;
    logic                          r_out_valid;
    logic [cbwq_pkg::CFG_W-1:0]    r_min_backoff;
    logic [cbwq_pkg::CFG_W-1:0]    r_max_backoff;

    // captured request
    logic [1:0]                    r_op;
    cbwq_pkg::t_key                r_key;
    logic [cbwq_pkg::TIME_W-1:0]   r_now;
    logic                          r_obs_valid;
    logic                          r_obs_conn;

    logic                          s_accept;
    logic                          out_load;
    logic                          scan_issue;
    logic [CW-1:0]                 cnt_diff;
    logic [CW-1:0]                 cnt;
    logic [CW+3:0]                 cnt_ext;
    cbwq_pkg::t_key                in_key;
    logic                          in_retry;

    logic                          ram_we;
    logic [PW-1:0]                 ram_waddr;
    cbwq_pkg::t_entry              ram_wdata;
    logic                          ram_re;
    logic [PW-1:0]                 ram_raddr;
    cbwq_pkg::t_entry              ram_q;

    cbwq_pkg::t_retire_req         bo_req;
    cbwq_pkg::t_retire_rsp         bo_rsp;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_key.from_root  = s_axis_tdata[0];
    assign in_key.source_id  = s_axis_tdata[4:1];
    assign in_key.generation = s_axis_tdata[20:5];
    assign in_key.port       = s_axis_tdata[28:21];
    assign in_retry          = s_axis_tdata[61];

    // queued entries, modulo ring size
    assign cnt_diff = {1'b0, r_wr_ptr} - {1'b0, r_rd_ptr};
    assign cnt      = (r_wr_ptr < r_rd_ptr) ? cnt_diff + CW'(QUEUE_DEPTH) : cnt_diff;
    assign cnt_ext  = {4'b0000, cnt};

    assign scan_issue = (r_scan != r_wr_ptr);

    assign bo_req.backoff     = ram_q.backoff;
    assign bo_req.retry_time  = ram_q.retry_time;
    assign bo_req.now         = r_now;
    assign bo_req.obs_valid   = r_obs_valid;
    assign bo_req.obs_conn    = r_obs_conn;
    assign bo_req.min_backoff = r_min_backoff;
    assign bo_req.max_backoff = r_max_backoff;

    cbwq_backoff u_backoff (
        .i_req (bo_req),
        .o_rsp (bo_rsp)
    );

    cbwq_entry_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_acc       = r_acc;
        n_mrg       = r_mrg;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_wr_ptr;
        ram_wdata   = ram_q;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_ptr;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_acc  = 1'b0;
                    n_mrg  = 1'b0;
                    n_scan = r_rd_ptr;
                    n_pend = 1'b0;
                    priority case (s_axis_tuser)
                        cbwq_pkg::OP_PUSH: begin
                            n_state = ST_SCAN;
                        end
                        cbwq_pkg::OP_RETIRE: begin
                            if (cnt == '0) begin
                                n_state = ST_HEAD;
                            end else if (!in_retry) begin
                                n_rd_ptr = next_slot(r_rd_ptr);
                                n_state  = ST_HEAD;
                            end else begin
                                n_state = ST_RREAD;
                            end
                        end
                        default: begin
                            n_state = ST_HEAD;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read one slot per cycle, compare the one read last cycle
                ram_re    = scan_issue;
                ram_raddr = r_scan;
                if (r_pend && (ram_q.key == r_key)) begin
                    n_acc = 1'b1;
                    n_mrg = 1'b1;
                    if (r_key.from_root) begin
                        ram_we                    = 1'b1;
                        ram_waddr                 = r_pend_addr;
                        ram_wdata.key             = ram_q.key;
                        ram_wdata.backoff.conn    = ram_q.backoff.conn;
                        ram_wdata.backoff.obs     = 1'b0;
                        ram_wdata.backoff.delay   = '0;
                        ram_wdata.retry_time      = '0;
                    end
                    n_state = ST_HEAD;
                end else if (!scan_issue) begin
                    n_state = ST_APPEND;
                end else begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_scan;
                    n_scan      = next_slot(r_scan);
                end
            end
            ST_APPEND: begin
                if (next_slot(r_wr_ptr) != r_rd_ptr) begin
                    ram_we               = 1'b1;
                    ram_waddr            = r_wr_ptr;
                    ram_wdata.key        = r_key;
                    ram_wdata.backoff    = '0;
                    ram_wdata.retry_time = '0;
                    n_wr_ptr             = next_slot(r_wr_ptr);
                    n_acc                = 1'b1;
                end
                n_state = ST_HEAD;
            end
            ST_RREAD: begin
                ram_re    = 1'b1;
                ram_raddr = r_rd_ptr;
                n_state   = ST_RMOD;
            end
            ST_RMOD: begin
                // backed-off head rotates to the tail slot
                ram_we               = 1'b1;
                ram_waddr            = r_wr_ptr;
                ram_wdata.key        = ram_q.key;
                ram_wdata.backoff    = bo_rsp.backoff;
                ram_wdata.retry_time = bo_rsp.retry_time;
                n_wr_ptr             = next_slot(r_wr_ptr);
                n_rd_ptr             = next_slot(r_rd_ptr);
                n_state              = ST_HEAD;
            end
            ST_HEAD: begin
                ram_re    = 1'b1;
                ram_raddr = r_rd_ptr;
                n_state   = ST_HWAIT;
            end
            ST_HWAIT: begin
                n_res.accepted    = r_acc;
                n_res.merged      = r_mrg;
                n_res.head_valid  = (cnt != '0);
                n_res.head_key    = (cnt != '0) ? ram_q.key : '0;
                n_res.head_ready  = (cnt != '0) && (r_op != cbwq_pkg::OP_PUSH)
                                    && cbwq_pkg::is_ready(ram_q.retry_time, r_now);
                n_res.queue_count = cnt_ext[3:0];
                n_state           = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_pend   <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_backoff <= cbwq_pkg::RESET_MIN_BACKOFF;
            r_max_backoff <= cbwq_pkg::RESET_MAX_BACKOFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cbwq_pkg::CFG_MIN_BACKOFF: r_min_backoff <= i_cfg_wdata;
                cbwq_pkg::CFG_MAX_BACKOFF: r_max_backoff <= i_cfg_wdata;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_pend_addr <= n_pend_addr;
        r_acc       <= n_acc;
        r_mrg       <= n_mrg;
        r_res       <= n_res;
        if (s_accept) begin
            r_op        <= s_axis_tuser;
            r_key       <= in_key;
            r_now       <= s_axis_tdata[60:29];
            r_obs_valid <= s_axis_tdata[62];
            r_obs_conn  <= s_axis_tdata[63];
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    // head key goes out from_root first, port last
    assign m_axis_tdata  = {3'b000, r_out.queue_count, r_out.head_key.port,
                            r_out.head_key.generation, r_out.head_key.source_id,
                            r_out.head_key.from_root, r_out.head_ready,
                            r_out.head_valid, r_out.merged, r_out.accepted};

endmodule

`default_nettype wire

/* hw/rtl/cbwq_checker.sv */
// ============================================================================
// cbwq_checker
// Port-level checks on the work queue, bound to the top level.
// ============================================================================
`default_nettype none

`include "coalescing_backoff_work_queue_core_assert.svh"

module cbwq_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [cbwq_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    // stalled result holds
    `CBWQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one request in flight: ready drops right after a request is taken
    `CBWQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a merge is always an accepted push
    `CBWQ_ASSERT_NOW(a_merge_accepted, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0])

    // empty ring reports a cleared head and a zero count
    `CBWQ_ASSERT_NOW(a_empty_head, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[2], (m_axis_tdata[36:3] == '0))

endmodule

bind coalescing_backoff_work_queue_core cbwq_checker u_cbwq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* dv/coalescing_backoff_work_queue_checker.sv */
// ============================================================================
// coalescing_backoff_work_queue_checker
// Watches the config port and both stream channels of the work queue core.
// Every accepted request is run through a local model of the ring, and the
// head status that it yields is queued. Each accepted result is checked
// field by field against the oldest queued status.
// ============================================================================

module coalescing_backoff_work_queue_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [cbwq_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    input  logic                               i_s_axis_tready,
    input  logic [cbwq_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic [cbwq_pkg::S_TUSER_W-1:0]     i_s_axis_tuser,
    input  logic                               i_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [cbwq_pkg::M_TDATA_W-1:0]     i_m_axis_tdata,
    output int                                 o_mismatch_count,
    output int                                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = cbwq_pkg::TIME_W;

    typedef struct packed {
        logic        accepted;
        logic        merged;
        logic        head_valid;
        logic        head_ready;
        logic        head_from_root;
        logic [3:0]  head_source_id;
        logic [15:0] head_generation;
        logic [7:0]  head_port;
        logic [3:0]  queue_count;
    } t_head_status;

    cbwq_pkg::t_key              ring_key  [QUEUE_DEPTH];
    cbwq_pkg::t_backoff          ring_bo   [QUEUE_DEPTH];
    logic [TW-1:0]               ring_time [QUEUE_DEPTH];
    int unsigned                 wr_slot;
    int unsigned                 rd_slot;
    logic [cbwq_pkg::CFG_W-1:0]  min_delay;
    logic [cbwq_pkg::CFG_W-1:0]  max_delay;
    t_head_status                expected_status_q[$];
    int                          mismatches;

    function automatic int unsigned ring_succ(input int unsigned p);
        return (p + 1) % QUEUE_DEPTH;
    endfunction

    // zero means always due; otherwise a wrapping signed compare
    function automatic logic retry_elapsed(input logic [TW-1:0] t,
                                           input logic [TW-1:0] now);
        logic [TW-1:0] lag;
        lag = now - t;
        return (t == '0) || !lag[TW-1];
    endfunction

    task automatic advance_work_ring(input logic [cbwq_pkg::S_TUSER_W-1:0] op,
                                     input logic [cbwq_pkg::S_TDATA_W-1:0] req,
                                     output t_head_status st);
        cbwq_pkg::t_key      key;
        logic [TW-1:0]       now;
        logic                retry;
        logic                obs_valid;
        logic                obs_conn;
        logic                hit;
        logic                was_due;
        int unsigned         c;
        int unsigned         h;
        int unsigned         n;
        logic [TW-1:0]       d;
        cbwq_pkg::t_backoff  bo;
        logic [TW-1:0]       rt;
        begin
            key.from_root  = req[0];
            key.source_id  = req[4:1];
            key.generation = req[20:5];
            key.port       = req[28:21];
            now       = req[60:29];
            retry     = req[61];
            obs_valid = req[62];
            obs_conn  = req[63];
            st = '0;

            if (op == cbwq_pkg::OP_PUSH) begin
                hit = 1'b0;
                c = rd_slot;
                while (c != wr_slot && !hit) begin
                    if (ring_key[c] == key) begin
                        hit = 1'b1;
                        // root events restart the backoff, keep the last state
                        if (key.from_root) begin
                            ring_bo[c].delay = '0;
                            ring_bo[c].obs   = 1'b0;
                            ring_time[c]     = '0;
                        end
                    end else begin
                        c = ring_succ(c);
                    end
                end
                st.accepted = hit;
                st.merged   = hit;
                if (!hit && ring_succ(wr_slot) != rd_slot) begin
                    ring_key[wr_slot]  = key;
                    ring_bo[wr_slot]   = '0;
                    ring_time[wr_slot] = '0;
                    wr_slot = ring_succ(wr_slot);
                    st.accepted = 1'b1;
                end
            end else if (op == cbwq_pkg::OP_RETIRE && wr_slot != rd_slot) begin
                h = rd_slot;
                if (retry) begin
                    was_due = retry_elapsed(ring_time[h], now);
                    bo = ring_bo[h];
                    rt = ring_time[h];
                    if (obs_valid) begin
                        if (!bo.obs || bo.conn != obs_conn) begin
                            bo.delay = '0;
                            rt = '0;
                        end
                        bo.obs  = 1'b1;
                        bo.conn = obs_conn;
                    end
                    if (was_due) begin
                        d = TW'(bo.delay);
                        if (d == '0) begin
                            d = TW'(min_delay);
                        end else if (d < TW'(max_delay)) begin
                            d = d << 1;
                            if (d > TW'(max_delay)) d = TW'(max_delay);
                        end
                        bo.delay = d[cbwq_pkg::DELAY_W-1:0];
                        rt = now + d;
                    end
                    ring_key[wr_slot]  = ring_key[h];
                    ring_bo[wr_slot]   = bo;
                    ring_time[wr_slot] = rt;
                    wr_slot = ring_succ(wr_slot);
                end
                rd_slot = ring_succ(h);
            end

            n = (wr_slot + QUEUE_DEPTH - rd_slot) % QUEUE_DEPTH;
            st.queue_count = n[3:0];
            if (n != 0) begin
                st.head_valid      = 1'b1;
                st.head_from_root  = ring_key[rd_slot].from_root;
                st.head_source_id  = ring_key[rd_slot].source_id;
                st.head_generation = ring_key[rd_slot].generation;
                st.head_port       = ring_key[rd_slot].port;
                st.head_ready      = (op != cbwq_pkg::OP_PUSH)
                                     && retry_elapsed(ring_time[rd_slot], now);
            end
        end
    endtask

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected %0h, got %0h", $realtime, label, want, seen);
        end
    endtask

    task automatic check_status(input logic [cbwq_pkg::M_TDATA_W-1:0] got);
        t_head_status want;
        begin
            if (expected_status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result %0h with no request outstanding", $realtime, got);
            end else begin
                want = expected_status_q.pop_front();
                compare_field("accepted",   32'(want.accepted),   32'(got[0]));
                compare_field("merged",     32'(want.merged),     32'(got[1]));
                compare_field("head_valid", 32'(want.head_valid), 32'(got[2]));
                compare_field("head_ready", 32'(want.head_ready), 32'(got[3]));
                compare_field("head_from_root", 32'(want.head_from_root), 32'(got[4]));
                compare_field("head_source_id", 32'(want.head_source_id), 32'(got[8:5]));
                compare_field("head_generation", 32'(want.head_generation),
                              32'(got[24:9]));
                compare_field("head_port",   32'(want.head_port),   32'(got[32:25]));
                compare_field("queue_count", 32'(want.queue_count), 32'(got[36:33]));
                compare_field("zero fill",   32'd0,                 32'(got[39:37]));
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_head_status st;
        if (!i_rst_n) begin
            wr_slot    = 0;
            rd_slot    = 0;
            min_delay  = cbwq_pkg::RESET_MIN_BACKOFF;
            max_delay  = cbwq_pkg::RESET_MAX_BACKOFF;
            mismatches = 0;
            expected_status_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == cbwq_pkg::CFG_MIN_BACKOFF)
                    min_delay = i_cfg_wdata;
                else
                    max_delay = i_cfg_wdata;
            end
            if (i_m_axis_tvalid && i_m_axis_tready)
                check_status(i_m_axis_tdata);
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                advance_work_ring(i_s_axis_tuser, i_s_axis_tdata, st);
                expected_status_q.push_back(st);
            end
        end
        o_outstanding    <= expected_status_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

/* dv/coalescing_backoff_work_queue_core_tb.sv */
// ============================================================================
// coalescing_backoff_work_queue_core_tb
// Drives the work queue core with a directed opening (empty ring, merges,
// backoff growth, observed state changes, wrapping retry time) followed by
// random push/peek/retire traffic over several backoff settings, with random
// gaps on both channels and one long result stall. Checking is done by the
// checker module instantiated alongside the core.
// ============================================================================

module coalescing_backoff_work_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE   = 2'd3;    // decodes as a peek
    localparam int CYCLE_LIMIT        = 400000;
    localparam int HOLD_CYCLES        = 400;
    localparam int NUM_PHASES         = 6;
    localparam int ITEMS_PER_PHASE    = 275;
    localparam int POOL_SIZE          = 24;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic                                i_cfg_index;
    logic [cbwq_pkg::CFG_W-1:0]          i_cfg_wdata;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    // from_root[0], source_id[4:1], source_generation[20:5], port[28:21],
    // now_ms[60:29], outcome_retry[61], observed_valid[62], observed_connected[63]
    logic [cbwq_pkg::S_TDATA_W-1:0]      s_axis_tdata;
    // operation[1:0]
    logic [cbwq_pkg::S_TUSER_W-1:0]      s_axis_tuser;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    // accepted[0], merged[1], head_valid[2], head_ready[3], head_from_root[4],
    // head_source_id[8:5], head_generation[24:9], head_port[32:25],
    // queue_count[36:33], zero fill[39:37]
    logic [cbwq_pkg::M_TDATA_W-1:0]      m_axis_tdata;

    int   mismatch_count;
    int   outstanding;
    int   tx_gap_max = 14;
    int   rx_gap_max = 14;
    logic rx_hold    = 1'b0;
    logic hold_req   = 1'b0;
    int   cycle_count;

    cbwq_pkg::t_key                  key_pool[POOL_SIZE];
    logic [cbwq_pkg::TIME_W-1:0]     now_ms;

    coalescing_backoff_work_queue_core #(
        .QUEUE_DEPTH(16)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    coalescing_backoff_work_queue_checker #(
        .QUEUE_DEPTH(16)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_s_axis_tvalid  (s_axis_tvalid),
        .i_s_axis_tready  (s_axis_tready),
        .i_s_axis_tdata   (s_axis_tdata),
        .i_s_axis_tuser   (s_axis_tuser),
        .i_m_axis_tvalid  (m_axis_tvalid),
        .i_m_axis_tready  (m_axis_tready),
        .i_m_axis_tdata   (m_axis_tdata),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls per result, plus the long hold
    initial begin : result_sink
        int unsigned gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(rx_gap_max);
            if (gap != 0 || rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    initial begin : result_hold
        wait (hold_req);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic offer(input logic [1:0] op,
                         input logic [cbwq_pkg::S_TDATA_W-1:0] data);
        int unsigned gap;
        begin
            gap = $urandom_range(tx_gap_max);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= data;
            s_axis_tuser  <= op;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
        end
    endtask

    // fields unused by the operation carry random bits
    task automatic push_event(input cbwq_pkg::t_key k);
        logic [cbwq_pkg::S_TDATA_W-1:0] d;
        begin
            d = {$urandom, $urandom};
            d[0]     = k.from_root;
            d[4:1]   = k.source_id;
            d[20:5]  = k.generation;
            d[28:21] = k.port;
            offer(cbwq_pkg::OP_PUSH, d);
        end
    endtask

    task automatic query_head(input logic [1:0] op,
                              input logic [cbwq_pkg::TIME_W-1:0] now);
        logic [cbwq_pkg::S_TDATA_W-1:0] d;
        begin
            d = {$urandom, $urandom};
            d[60:29] = now;
            offer(op, d);
        end
    endtask

    task automatic retire_head(input logic [cbwq_pkg::TIME_W-1:0] now, input logic retry,
                               input logic obs_valid, input logic obs_conn);
        logic [cbwq_pkg::S_TDATA_W-1:0] d;
        begin
            d = {$urandom, $urandom};
            d[60:29] = now;
            d[61]    = retry;
            d[62]    = obs_valid;
            d[63]    = obs_conn;
            offer(cbwq_pkg::OP_RETIRE, d);
        end
    endtask

    function automatic cbwq_pkg::t_key random_key();
        logic [31:0]    r;
        cbwq_pkg::t_key k;
        r = $urandom;
        k = r[28:0];
        if (k.from_root && r[31]) k.generation = '0;
        return k;
    endfunction

    task automatic write_backoff_limits(input logic [cbwq_pkg::CFG_W-1:0] lo,
                                        input logic [cbwq_pkg::CFG_W-1:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= cbwq_pkg::CFG_MIN_BACKOFF;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_index <= cbwq_pkg::CFG_MAX_BACKOFF;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // the extra edge lets the checker log a request taken on the last edge
    task automatic wait_idle();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        cbwq_pkg::t_key               key_ones;
        cbwq_pkg::t_key               key_zero;
        int                           push_pct;
        int unsigned                  pick;
        logic [31:0]                  obs_bits;
        logic [cbwq_pkg::CFG_W-1:0]   new_min;
        logic [cbwq_pkg::CFG_W-1:0]   new_max;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= cbwq_pkg::CFG_MIN_BACKOFF;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= cbwq_pkg::OP_PUSH;
        key_ones = '1;
        key_zero = '0;
        for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = random_key();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening, reset limits 10/1000
        query_head(cbwq_pkg::OP_PEEK, 32'd0);
        retire_head(32'd0, 1'b1, 1'b1, 1'b1);        // empty ring, ignored
        query_head(OP_SPARE, 32'd0);
        push_event(key_ones);
        push_event(key_zero);
        push_event(key_zero);                        // hub merge
        query_head(cbwq_pkg::OP_PEEK, 32'd0);
        retire_head(32'd100, 1'b1, 1'b1, 1'b1);      // first retry: min delay
        retire_head(32'd200, 1'b1, 1'b0, 1'b0);
        query_head(cbwq_pkg::OP_PEEK, 32'd105);      // not yet due
        retire_head(32'd105, 1'b1, 1'b1, 1'b1);      // early retry keeps delay
        retire_head(32'd300, 1'b1, 1'b1, 1'b0);      // first observation clears
        retire_head(32'd500, 1'b1, 1'b1, 1'b0);      // connection change clears
        retire_head(32'd400, 1'b1, 1'b0, 1'b0);      // delay doubles
        push_event(key_zero);                        // hub merge keeps backoff
        push_event(key_ones);                        // root merge clears backoff
        retire_head(32'hFFFF_FFF6, 1'b1, 1'b0, 1'b0); // retry time wraps to zero
        retire_head(32'h8000_0000, 1'b0, 1'b0, 1'b0);
        query_head(cbwq_pkg::OP_PEEK, 32'h8000_0000); // zero retry time is due
        retire_head(32'd0, 1'b0, 1'b0, 1'b0);
        query_head(cbwq_pkg::OP_PEEK, 32'd0);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        now_ms = $urandom;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    new_min = 10'd1;    new_max = 10'd1023; push_pct = 50;
                    tx_gap_max = 14;    rx_gap_max = 14;
                end
                1: begin
                    new_min = 10'd1023; new_max = 10'd1;    push_pct = 80;
                    tx_gap_max = 0;     rx_gap_max = 0;
                end
                2: begin
                    new_min = 10'd1023; new_max = 10'd1023; push_pct = 35;
                    tx_gap_max = 14;    rx_gap_max = 0;
                end
                3: begin
                    new_min = 10'd1;    new_max = 10'd1;    push_pct = 40;
                    tx_gap_max = 0;     rx_gap_max = 14;
                end
                4: begin
                    pick = $urandom_range(1023, 1);
                    new_min = pick[cbwq_pkg::CFG_W-1:0];
                    pick = $urandom_range(1023, 1);
                    new_max = pick[cbwq_pkg::CFG_W-1:0];
                    push_pct = 45;
                    tx_gap_max = 14;    rx_gap_max = 14;
                end
                default: begin
                    new_min = cbwq_pkg::RESET_MIN_BACKOFF;
                    new_max = cbwq_pkg::RESET_MAX_BACKOFF;
                    push_pct = 25;
                    tx_gap_max = 14;    rx_gap_max = 14;
                end
            endcase
            write_backoff_limits(new_min, new_max);
            // long result stall while requests keep coming
            if (ph == 1) hold_req = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    now_ms = 32'hFFFF_FE00 + $urandom_range(255);
                else if (pick < 5)
                    now_ms = $urandom;
                else
                    now_ms = now_ms + $urandom_range(400);

                if ($urandom_range(99) < push_pct) begin
                    if ($urandom_range(99) < 15)
                        push_event(random_key());
                    else
                        push_event(key_pool[$urandom_range(POOL_SIZE - 1)]);
                end else begin
                    pick = $urandom_range(99);
                    obs_bits = $urandom;
                    if (pick < 30)
                        query_head(cbwq_pkg::OP_PEEK, now_ms);
                    else if (pick < 38)
                        query_head(OP_SPARE, now_ms);
                    else
                        retire_head(now_ms, $urandom_range(99) < 65,
                                    obs_bits[0], obs_bits[1]);
                end
            end
            s_axis_tvalid <= 1'b0;
            wait_idle();
        end

        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
